[src/irt_pkg.sv]
`timescale 1ns / 1ps

package irt_pkg;

    localparam int STATUS_W = 3;
    localparam int TAG_W    = 16;
    localparam int POS_W    = 16;
    localparam int ROW_W    = 10;

    typedef logic [STATUS_W-1:0] t_status;
    typedef logic                t_op;

    localparam t_op OP_RESERVE = 1'b0;
    localparam t_op OP_LOOKUP  = 1'b1;

    localparam t_status ST_RESERVED = 3'd0;
    localparam t_status ST_OVERLAP  = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_FOUND    = 3'd3;
    localparam t_status ST_NONE     = 3'd4;

endpackage

[src/irt_ram.sv]
`timescale 1ns / 1ps

module irt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/irt_match.sv]
`timescale 1ns / 1ps

// Row and endpoint (reserve) or query position (lookup) compare against one stored entry.
module irt_match #(
    parameter int RB = 10,
    parameter int PW = 16
) (
    input  irt_pkg::t_op  i_op,
    input  logic [RB-1:0] i_row,
    input  logic [PW-1:0] i_start,
    input  logic [PW-1:0] i_end,
    input  logic [PW-1:0] i_query,
    input  logic [RB-1:0] i_ent_row,
    input  logic [PW-1:0] i_ent_start,
    input  logic [PW-1:0] i_ent_end,
    output logic          o_hit
);

    import irt_pkg::*;

    logic w_s_in_ent;
    logic w_e_in_ent;
    logic w_a_in_new;
    logic w_b_in_new;
    logic w_q_in_ent;
    logic w_row_eq;

    assign w_row_eq   = (i_row == i_ent_row);
    assign w_s_in_ent = (i_ent_start <= i_start) && (i_ent_end >= i_start);
    assign w_e_in_ent = (i_ent_start <= i_end) && (i_ent_end >= i_end);
    assign w_a_in_new = (i_start <= i_ent_start) && (i_end >= i_ent_start);
    assign w_b_in_new = (i_start <= i_ent_end) && (i_end >= i_ent_end);
    assign w_q_in_ent = (i_ent_start <= i_query) && (i_ent_end >= i_query);

    always_comb begin
        if (i_op == OP_LOOKUP) begin
            o_hit = w_row_eq && w_q_in_ent;
        end else begin
            o_hit = w_row_eq && (w_s_in_ent || w_e_in_ent || w_a_in_new || w_b_in_new);
        end
    end

endmodule

[src/interval_reservation_table_unit.sv]
`timescale 1ns / 1ps

// Interval reservation table.
// Input channel (i_in_valid / o_in_stall): one item is a reserve (op 0) of an
// inclusive range in a row, or a lookup (op 1) of the owner of one position.
// Output channel (o_out_valid / i_out_stall): exactly one result item per
// input item, in order: status and, for a found owner, its tag.
// Each item scans the stored entries in insertion order, one entry per cycle
// from a single-port-read table RAM, through one compare unit. The scan covers
// up to count entries (count = entries stored, up to CAPACITY), stopping
// early at the first hit; a row at or above ROW_COUNT or an empty table skips
// the scan. A reserve that passes is appended to the RAM in the final cycle.
// o_in_stall is high from acceptance until the result is loaded into the
// output register. A stalled result holds in that register; the next item
// may be accepted and scanned meanwhile, then waits for the register to free.
// Reset empties the table (fill count to zero) and drops any pending result;
// no clearing pass is needed, only entries below the fill count are read.
module interval_reservation_table_unit #(
    parameter int CAPACITY  = 64,
    parameter int ROW_COUNT = 1024,
    parameter int POS_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_op,
    input  logic [irt_pkg::ROW_W-1:0] i_row_index,
    input  logic [irt_pkg::POS_W-1:0] i_start_pos,
    input  logic [irt_pkg::POS_W-1:0] i_end_pos,
    input  logic [irt_pkg::TAG_W-1:0] i_owner_tag,
    input  logic [irt_pkg::POS_W-1:0] i_query_pos,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output irt_pkg::t_status         o_status,
    output logic [irt_pkg::TAG_W-1:0] o_found_owner
);

    import irt_pkg::*;

    localparam int PW = (POS_BITS < POS_W) ? POS_BITS : POS_W;
    localparam int RB = (ROW_COUNT >= 1024) ? ROW_W :
                        ((ROW_COUNT <= 2) ? 1 : $clog2(ROW_COUNT));
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int EW = RB + 2 * PW + TAG_W;
    localparam logic [16:0] RowLimit = 17'(ROW_COUNT);
    localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_rd_idx, n_rd_idx;
    logic            r_pend, n_pend;
    logic            r_pend_last, n_pend_last;
    logic            r_hit, n_hit;
    logic [TAG_W-1:0] r_hit_owner, n_hit_owner;

    t_op             r_op;
    logic [RB-1:0]   r_row;
    logic            r_row_ok;
    logic [PW-1:0]   r_start, r_end, r_query;
    logic [TAG_W-1:0] r_tag;

    logic            r_out_valid, n_out_valid;
    t_status         r_status, n_status;
    logic [TAG_W-1:0] r_owner, n_owner;

    logic            w_accept;
    logic            w_row_ok;
    logic            w_load;
    logic            w_we;
    logic [EW-1:0]   w_wdata;
    logic [EW-1:0]   w_rdata;
    logic [RB-1:0]   w_ent_row;
    logic [PW-1:0]   w_ent_start, w_ent_end;
    logic [TAG_W-1:0] w_ent_owner;
    logic            w_match;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_row_ok = {7'd0, i_row_index} < RowLimit;
    assign w_load   = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign w_we     = w_load && (r_op == OP_RESERVE) && r_row_ok && !r_hit &&
                      (r_count != CapCount);
    assign w_wdata  = {r_row, r_start, r_end, r_tag};

    assign {w_ent_row, w_ent_start, w_ent_end, w_ent_owner} = w_rdata;

    irt_ram #(
        .WIDTH(EW),
        .DEPTH(CAPACITY)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_count[IW-1:0]),
        .i_wdata(w_wdata),
        .i_raddr(r_rd_idx[IW-1:0]),
        .o_rdata(w_rdata)
    );

    irt_match #(
        .RB(RB),
        .PW(PW)
    ) u_match (
        .i_op       (r_op),
        .i_row      (r_row),
        .i_start    (r_start),
        .i_end      (r_end),
        .i_query    (r_query),
        .i_ent_row  (w_ent_row),
        .i_ent_start(w_ent_start),
        .i_ent_end  (w_ent_end),
        .o_hit      (w_match)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_hit       = r_hit;
        n_hit_owner = r_hit_owner;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_owner     = r_owner;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_hit    = 1'b0;
                    n_rd_idx = '0;
                    if (w_row_ok && (r_count != '0)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend && w_match) begin
                    n_hit       = 1'b1;
                    n_hit_owner = w_ent_owner;
                    n_state     = S_FIN;
                end else if (r_pend && r_pend_last) begin
                    n_state = S_FIN;
                end else if (r_rd_idx != r_count) begin
                    // issue the next read; its data is compared in the following cycle
                    n_pend      = 1'b1;
                    n_pend_last = (r_rd_idx == r_count - CW'(1));
                    n_rd_idx    = r_rd_idx + CW'(1);
                end
            end
            S_FIN: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_owner     = '0;
                    n_state     = S_IDLE;
                    if (r_op == OP_LOOKUP) begin
                        if (r_hit) begin
                            n_status = ST_FOUND;
                            n_owner  = r_hit_owner;
                        end else begin
                            n_status = ST_NONE;
                        end
                    end else if (!r_row_ok) begin
                        n_status = ST_FULL;
                    end else if (r_hit) begin
                        n_status = ST_OVERLAP;
                    end else if (r_count == CapCount) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_RESERVED;
                        n_count  = r_count + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_pend_last <= n_pend_last;
        r_hit       <= n_hit;
        r_hit_owner <= n_hit_owner;
        r_status    <= n_status;
        r_owner     <= n_owner;
        if (w_accept) begin
            r_op     <= i_op;
            r_row    <= i_row_index[RB-1:0];
            r_row_ok <= w_row_ok;
            r_start  <= i_start_pos[PW-1:0];
            r_end    <= i_end_pos[PW-1:0];
            r_query  <= i_query_pos[PW-1:0];
            r_tag    <= i_owner_tag;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_owner = r_owner;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("block took a second item while the first was in work");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CapCount)
        else $error("fill count above capacity");

    a_owner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_FOUND)) |-> (o_found_owner == '0))
        else $error("owner tag given without a found owner");

    a_count_on_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_we |=> (r_count == $past(r_count)))
        else $error("fill count moved without an append");

endmodule

[test/tb_interval_reservation_table_unit.sv]
`timescale 1ns / 1ps

module tb_interval_reservation_table_unit;
    import irt_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int ROW_COUNT    = 1024;
    localparam int POS_BITS     = 16;
    localparam int RANDOM_ITEMS = 680;
    localparam int HOLD_CYCLES  = 2000;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [POS_W-1:0] POS_MASK = POS_W'((64'd1 << POS_BITS) - 64'd1);

    typedef struct packed {
        t_status            status;
        logic [TAG_W-1:0]   owner;
    } t_lookup_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_op;
    logic [ROW_W-1:0]   i_row_index;
    logic [POS_W-1:0]   i_start_pos;
    logic [POS_W-1:0]   i_end_pos;
    logic [TAG_W-1:0]   i_owner_tag;
    logic [POS_W-1:0]   i_query_pos;
    logic               o_out_valid;
    logic               i_out_stall;
    t_status            o_status;
    logic [TAG_W-1:0]   o_found_owner;

    // shadow copy of the reservation table
    logic [ROW_W-1:0]   tbl_row   [CAPACITY];
    logic [POS_W-1:0]   tbl_lo    [CAPACITY];
    logic [POS_W-1:0]   tbl_hi    [CAPACITY];
    logic [TAG_W-1:0]   tbl_owner [CAPACITY];
    int                 tbl_fill = 0;

    t_lookup_result     pending_results[$];
    int                 mismatches = 0;
    int                 result_index = 0;
    int                 idle_cycles = 0;
    bit                 no_idle = 1'b0;
    bit                 hold_req = 1'b0;

    interval_reservation_table_unit #(
        .CAPACITY  (CAPACITY),
        .ROW_COUNT (ROW_COUNT),
        .POS_BITS  (POS_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_row_index   (i_row_index),
        .i_start_pos   (i_start_pos),
        .i_end_pos     (i_end_pos),
        .i_owner_tag   (i_owner_tag),
        .i_query_pos   (i_query_pos),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_found_owner (o_found_owner)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit covers(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi,
                                  logic [POS_W-1:0] p);
        return lo <= p && hi >= p;
    endfunction

    // Applies one request to the shadow table and returns the answer.
    function automatic t_lookup_result table_outcome(t_op op, logic [ROW_W-1:0] row,
            logic [POS_W-1:0] s_raw, logic [POS_W-1:0] e_raw,
            logic [TAG_W-1:0] tag, logic [POS_W-1:0] q_raw);
        t_lookup_result r;
        logic [POS_W-1:0] s, e, q;
        bit hit;
        bit row_ok;
        s = s_raw & POS_MASK;
        e = e_raw & POS_MASK;
        q = q_raw & POS_MASK;
        row_ok = int'(row) < ROW_COUNT;
        hit = 1'b0;
        r.owner = '0;
        if (op == OP_RESERVE) begin
            if (row_ok) begin
                for (int i = 0; i < tbl_fill && !hit; i++) begin
                    if (tbl_row[i] == row &&
                        (covers(tbl_lo[i], tbl_hi[i], s) || covers(tbl_lo[i], tbl_hi[i], e) ||
                         covers(s, e, tbl_lo[i]) || covers(s, e, tbl_hi[i])))
                        hit = 1'b1;
                end
            end
            if (!row_ok) begin
                r.status = ST_FULL;
            end else if (hit) begin
                r.status = ST_OVERLAP;
            end else if (tbl_fill >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                tbl_row[tbl_fill]   = row;
                tbl_lo[tbl_fill]    = s;
                tbl_hi[tbl_fill]    = e;
                tbl_owner[tbl_fill] = tag;
                tbl_fill++;
                r.status = ST_RESERVED;
            end
        end else begin
            r.status = ST_NONE;
            if (row_ok) begin
                for (int i = 0; i < tbl_fill && !hit; i++) begin
                    if (tbl_row[i] == row && covers(tbl_lo[i], tbl_hi[i], q)) begin
                        hit = 1'b1;
                        r.status = ST_FOUND;
                        r.owner = tbl_owner[i];
                    end
                end
            end
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 150);
    endfunction

    function automatic logic [ROW_W-1:0] pick_row();
        if ($urandom_range(0, 4) != 0)
            return ROW_W'($urandom_range(0, 7));
        return ROW_W'($urandom);
    endfunction

    task automatic send_item(input t_op op, input logic [ROW_W-1:0] row,
            input logic [POS_W-1:0] s, input logic [POS_W-1:0] e,
            input logic [TAG_W-1:0] tag, input logic [POS_W-1:0] q);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        // valid is only lowered when a gap follows, never dropped and raised in one step
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_row_index <= row;
        i_start_pos <= s;
        i_end_pos   <= e;
        i_owner_tag <= tag;
        i_query_pos <= q;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(table_outcome(op, row, s, e, tag, q));
    endtask

    task automatic reserve(input logic [ROW_W-1:0] row, input logic [POS_W-1:0] s,
            input logic [POS_W-1:0] e, input logic [TAG_W-1:0] tag);
        send_item(OP_RESERVE, row, s, e, tag, POS_W'($urandom));
    endtask

    task automatic lookup(input logic [ROW_W-1:0] row, input logic [POS_W-1:0] q);
        send_item(OP_LOOKUP, row, POS_W'($urandom), POS_W'($urandom), TAG_W'($urandom), q);
    endtask

    task automatic send_random_item();
        int r;
        int idx;
        logic [ROW_W-1:0] row;
        logic [POS_W-1:0] s, e, q;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            send_item(t_op'($urandom_range(0, 1)), ROW_W'($urandom), POS_W'($urandom),
                      POS_W'($urandom), TAG_W'($urandom), POS_W'($urandom));
        end else if (r < 40) begin
            row = pick_row();
            s = POS_W'($urandom);
            e = s + POS_W'($urandom_range(0, 3000));
            // now and then aim at a stored range to provoke an overlap
            if (tbl_fill > 0 && $urandom_range(0, 5) == 0) begin
                idx = $urandom_range(0, tbl_fill - 1);
                row = tbl_row[idx];
                s = tbl_lo[idx] - POS_W'($urandom_range(0, 200));
                e = s + POS_W'($urandom_range(0, 400));
            end
            reserve(row, s, e, TAG_W'($urandom));
        end else begin
            row = pick_row();
            q = POS_W'($urandom);
            if (tbl_fill > 0 && $urandom_range(0, 9) < 7) begin
                idx = $urandom_range(0, tbl_fill - 1);
                row = tbl_row[idx];
                case ($urandom_range(0, 4))
                    0: q = tbl_lo[idx];
                    1: q = tbl_hi[idx];
                    2: q = tbl_lo[idx] - POS_W'(1);
                    3: q = tbl_hi[idx] + POS_W'(1);
                    default: q = tbl_lo[idx] + POS_W'($urandom_range(0, 3000));
                endcase
            end
            lookup(row, q);
        end
    endtask

    task automatic test_directed();
        lookup(10'd0, 16'd0);                           // empty table
        reserve(10'd0, 16'd0, 16'd0, 16'h0000);
        reserve(10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        lookup(10'd0, 16'd0);
        lookup(10'd1023, 16'hFFFF);
        lookup(10'd1023, 16'hFFFE);
        reserve(10'd0, 16'd100, 16'd200, 16'h1234);
        reserve(10'd0, 16'd150, 16'd300, 16'h0001);     // start inside
        reserve(10'd0, 16'd50, 16'd100, 16'h0002);      // end inside
        reserve(10'd0, 16'd10, 16'd500, 16'h0003);      // covers stored range
        reserve(10'd0, 16'd120, 16'd180, 16'h0004);     // within stored range
        reserve(10'd1, 16'd100, 16'd200, 16'h0005);     // same span, other row
        reserve(10'd0, 16'd201, 16'd99, 16'h0006);      // inverted, clear of others
        lookup(10'd0, 16'd150);
        lookup(10'd0, 16'd201);
        reserve(10'd0, 16'd250, 16'd150, 16'h0007);     // inverted, end inside
        reserve(10'd2, 16'd0, 16'hFFFF, 16'hAAAA);
        lookup(10'd2, 16'h8000);
        reserve(10'd2, 16'hFFFF, 16'h0000, 16'h5555);   // inverted, endpoints inside
        lookup(10'd3, 16'd0);
        lookup(10'd1, 16'd201);
        lookup(10'd1, 16'd200);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (40) send_random_item();
        no_idle = 1'b0;
    endtask

    // receiver holds off long enough for the block to back up into its input
    task automatic test_receiver_hold();
        hold_req = 1'b1;
        repeat (16) send_random_item();
    endtask

    task automatic test_random_mix();
        repeat (RANDOM_ITEMS) send_random_item();
    endtask

    task automatic test_full_table();
        int k;
        k = 0;
        while (tbl_fill < CAPACITY && k < 4096) begin
            reserve(10'd1000, POS_W'(k * 16), POS_W'(k * 16 + 7), TAG_W'(k));
            k++;
        end
        reserve(10'd1001, 16'd0, 16'd0, 16'h0001);      // no overlap, no space
        reserve(tbl_row[0], tbl_lo[0], tbl_lo[0], 16'h0002); // overlap wins over full
        lookup(tbl_row[CAPACITY-1], tbl_lo[CAPACITY-1]);
        lookup(tbl_row[0], tbl_hi[0]);
    endtask

    task automatic finish_run();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = OP_RESERVE;
        i_row_index = '0;
        i_start_pos = '0;
        i_end_pos   = '0;
        i_owner_tag = '0;
        i_query_pos = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_back_to_back();
        test_receiver_hold();
        test_random_mix();
        test_full_table();
        test_back_to_back();
        finish_run();
    end

    // receiver: bursts of stall and no stall
    initial begin
        int len;
        bit level;
        i_out_stall = 1'b0;
        forever begin
            if (hold_req) begin
                level = 1'b1;
                len = HOLD_CYCLES;
                hold_req = 1'b0;
            end else if (no_idle) begin
                level = 1'b0;
                len = 1;
            end else begin
                level = ($urandom_range(0, 2) == 0);
                len = level ? pick_gap() + 1 : $urandom_range(1, 60);
            end
            repeat (len) begin
                i_out_stall <= level;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result, status %0d owner %h",
                             $realtime, o_status, o_found_owner);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %0d status expected %0d got %0d",
                                 $realtime, result_index, want.status, o_status);
                end
                if (o_found_owner !== want.owner) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %0d owner expected %h got %h",
                                 $realtime, result_index, want.owner, o_found_owner);
                end
            end
            result_index++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
